// ===== rtl/ate_pkg.sv =====
// Package of the alignment trace expander: trace codes, error codes, register addresses,
// default counter widths, request and result item types and the configuration register type.
// Depends on nothing; every rtl file refers to it by scoped names.
package ate_pkg;

    // Trace operation codes carried in req_type.
    localparam logic [2:0] CODE_BLOCK_MATCH  = 3'd0;
    localparam logic [2:0] CODE_MATCH        = 3'd1;
    localparam logic [2:0] CODE_BLOCK_DELETE = 3'd2;
    localparam logic [2:0] CODE_DELETE       = 3'd3;
    localparam logic [2:0] CODE_PLAIN        = 3'd4;
    localparam logic [2:0] CODE_INSERT       = 3'd5;
    localparam logic [2:0] CODE_END          = 3'd6;
    localparam logic [2:0] CODE_INVALID      = 3'd7;

    // Sticky error codes.
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_BAD_CODE      = 3'd1;
    localparam logic [2:0] ERR_INS_OVERFLOW  = 3'd2;
    localparam logic [2:0] ERR_REAL_OVERRUN  = 3'd3;
    localparam logic [2:0] ERR_INS_NO_ENTRY  = 3'd4;

    // Configuration register addresses, selected by paddr bit 2.
    localparam logic REG_SEQ_LENGTH  = 1'b0;
    localparam logic REG_START_INDEX = 1'b1;

    // Default widths of the internal counters.
    localparam int POS_BITS_DEFAULT    = 16;
    localparam int INSERT_BITS_DEFAULT = 15;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] residue;
    } req_item_t;

    typedef struct packed {
        logic [15:0] gap_position;
        logic [7:0]  gap_residue;
        logic [15:0] real_position;
        logic        deleted;
        logic [14:0] inserts_after;
        logic        block_begins;
        logic        last_entry;
        logic [15:0] total_length;
        logic [15:0] gap_opens;
        logic [15:0] deletion_total;
        logic [15:0] insertion_total;
        logic [2:0]  error_code;
    } rsp_item_t;

    typedef struct packed {
        logic [15:0] seq_length;
        logic [15:0] start_index;
    } cfg_regs_t;

endpackage

// ===== rtl/alignment_trace_expander_top.sv =====
// Top level of the alignment trace expander: trace state, per-code update
// logic and the result queue. Depends on ate_pkg, ate_cfg and ate_skid.
//
//  channel   direction  handshake                 payload
//  request   in         req_valid / req_ready     req_item   (ate_pkg::req_item_t)
//  result    out        rsp_valid / rsp_ready     rsp_item   (ate_pkg::rsp_item_t)
//  config    in         psel / penable / pready   paddr, pwdata, prdata
//
// One request is taken per cycle while req_ready is high. A result it causes goes to
// the output register on the next cycle, or to the skid register while an earlier
// result still waits. The rate is set by the trace state update. req_ready drops
// only when both result slots are full, so a request still goes in while one result
// waits. Reset clears all trace state at once; there is no clearing pass.
module alignment_trace_expander_top #(
    parameter int POS_BITS    = ate_pkg::POS_BITS_DEFAULT,
    parameter int INSERT_BITS = ate_pkg::INSERT_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ate_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ate_pkg::rsp_item_t rsp_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Compare width covering positions, the sequence length and insert counts.
    localparam int CW = 33;
    localparam logic [CW-1:0] INS_MAX = CW'((33'd1 << INSERT_BITS) - 33'd1);

    ate_pkg::cfg_regs_t cfg;

    // Trace state.
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_del_reg, pend_del_next;
    logic                   pend_blk_reg, pend_blk_next;
    logic [POS_BITS-1:0]    pend_pos_reg, pend_pos_next;
    logic [7:0]             pend_res_reg, pend_res_next;
    logic [POS_BITS-1:0]    pend_real_reg, pend_real_next;
    logic [INSERT_BITS-1:0] pend_ins_reg, pend_ins_next;
    logic [POS_BITS-1:0]    entry_cnt_reg, entry_cnt_next;
    logic [POS_BITS-1:0]    real_cnt_reg, real_cnt_next;
    logic [2:0]             prev_code_reg, prev_code_next;
    logic [15:0]            open_cnt_reg, open_cnt_next;
    logic [15:0]            del_cnt_reg, del_cnt_next;
    logic [15:0]            ins_cnt_reg, ins_cnt_next;
    logic [2:0]             err_reg, err_next;

    logic                   req_fire;
    logic                   push;
    ate_pkg::rsp_item_t     push_item;
    logic [2:0]             code;
    logic [POS_BITS-1:0]    real_base;
    logic [POS_BITS-1:0]    real_adv;
    logic                   adv_err;
    logic [CW-1:0]          unread;
    logic                   is_delete;

    ate_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign req_fire  = req_valid && req_ready;
    assign code      = req_item.req_type;
    assign is_delete = (code == ate_pkg::CODE_BLOCK_DELETE) || (code == ate_pkg::CODE_DELETE);

    // A new trace starts from start_index; one advance of the real index.
    assign real_base = (prev_code_reg == ate_pkg::CODE_END)
                     ? POS_BITS'(cfg.start_index) : real_cnt_reg;
    assign real_adv  = real_base + POS_BITS'(1);
    assign adv_err   = (CW'(real_adv) > CW'(cfg.seq_length)) || (real_adv == '0);

    // Per-code update of the trace state and the result it causes.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_del_next   = pend_del_reg;
        pend_blk_next   = pend_blk_reg;
        pend_pos_next   = pend_pos_reg;
        pend_res_next   = pend_res_reg;
        pend_real_next  = pend_real_reg;
        pend_ins_next   = pend_ins_reg;
        entry_cnt_next  = entry_cnt_reg;
        real_cnt_next   = real_cnt_reg;
        prev_code_next  = prev_code_reg;
        open_cnt_next   = open_cnt_reg;
        del_cnt_next    = del_cnt_reg;
        ins_cnt_next    = ins_cnt_reg;
        err_next        = err_reg;
        unread          = '0;
        push            = 1'b0;
        push_item       = '0;

        case (code)
            ate_pkg::CODE_INVALID:
            begin
                if (err_next == ate_pkg::ERR_NONE)
                begin
                    err_next = ate_pkg::ERR_BAD_CODE;
                end
            end
            ate_pkg::CODE_INSERT:
            begin
                real_cnt_next = real_base;
                if (!pend_valid_reg)
                begin
                    if (err_next == ate_pkg::ERR_NONE)
                    begin
                        err_next = ate_pkg::ERR_INS_NO_ENTRY;
                    end
                end
                else
                begin
                    real_cnt_next = real_adv;
                    if (adv_err && err_next == ate_pkg::ERR_NONE)
                    begin
                        err_next = ate_pkg::ERR_REAL_OVERRUN;
                    end
                    if (prev_code_reg != ate_pkg::CODE_INSERT)
                    begin
                        open_cnt_next = open_cnt_reg + 16'd1;
                    end
                    ins_cnt_next = ins_cnt_reg + 16'd1;
                    if (CW'(pend_ins_reg) >= INS_MAX)
                    begin
                        if (err_next == ate_pkg::ERR_NONE)
                        begin
                            err_next = ate_pkg::ERR_INS_OVERFLOW;
                        end
                    end
                    else
                    begin
                        pend_ins_next = pend_ins_reg + INSERT_BITS'(1);
                    end
                    prev_code_next = code;
                end
            end
            ate_pkg::CODE_END:
            begin
                // Unread residues become the insert count of the last entry.
                if (CW'(real_base) <= CW'(cfg.seq_length))
                begin
                    unread = CW'(cfg.seq_length) - CW'(real_base);
                end
                else if (err_next == ate_pkg::ERR_NONE)
                begin
                    err_next = ate_pkg::ERR_REAL_OVERRUN;
                end
                if (unread > INS_MAX)
                begin
                    unread = INS_MAX;
                    if (err_next == ate_pkg::ERR_NONE)
                    begin
                        err_next = ate_pkg::ERR_INS_OVERFLOW;
                    end
                end
                push = 1'b1;
                if (pend_valid_reg)
                begin
                    push_item.gap_position  = 16'(pend_pos_reg);
                    push_item.gap_residue   = pend_res_reg;
                    push_item.real_position = 16'(pend_real_reg);
                    push_item.deleted       = pend_del_reg;
                    push_item.inserts_after = 15'(INSERT_BITS'(unread));
                    push_item.block_begins  = pend_blk_reg;
                end
                push_item.last_entry      = 1'b1;
                push_item.total_length    = 16'(entry_cnt_reg);
                push_item.gap_opens       = open_cnt_reg;
                push_item.deletion_total  = del_cnt_reg;
                push_item.insertion_total = ins_cnt_reg;
                push_item.error_code      = err_next;

                // Clear for the next trace.
                pend_valid_next = 1'b0;
                pend_del_next   = 1'b0;
                pend_blk_next   = 1'b0;
                pend_pos_next   = '0;
                pend_res_next   = '0;
                pend_real_next  = '0;
                pend_ins_next   = '0;
                entry_cnt_next  = '0;
                real_cnt_next   = POS_BITS'(cfg.start_index);
                prev_code_next  = ate_pkg::CODE_END;
                open_cnt_next   = '0;
                del_cnt_next    = '0;
                ins_cnt_next    = '0;
                err_next        = ate_pkg::ERR_NONE;
            end
            default:
            begin
                // Match, delete and plain codes open a new pending entry.
                real_cnt_next = real_base;
                if (is_delete)
                begin
                    if ((prev_code_reg != ate_pkg::CODE_BLOCK_DELETE)
                        && (prev_code_reg != ate_pkg::CODE_DELETE))
                    begin
                        open_cnt_next = open_cnt_reg + 16'd1;
                    end
                    del_cnt_next = del_cnt_reg + 16'd1;
                end
                else
                begin
                    real_cnt_next = real_adv;
                    if (adv_err && err_next == ate_pkg::ERR_NONE)
                    begin
                        err_next = ate_pkg::ERR_REAL_OVERRUN;
                    end
                end
                if (pend_valid_reg)
                begin
                    push                    = 1'b1;
                    push_item.gap_position  = 16'(pend_pos_reg);
                    push_item.gap_residue   = pend_res_reg;
                    push_item.real_position = 16'(pend_real_reg);
                    push_item.deleted       = pend_del_reg;
                    push_item.inserts_after = 15'(pend_ins_reg);
                    push_item.block_begins  = pend_blk_reg;
                    push_item.error_code    = err_next;
                end
                entry_cnt_next  = entry_cnt_reg + POS_BITS'(1);
                pend_valid_next = 1'b1;
                pend_pos_next   = entry_cnt_next;
                pend_del_next   = is_delete;
                pend_res_next   = is_delete ? 8'd0 : req_item.residue;
                pend_real_next  = real_cnt_next;
                pend_ins_next   = '0;
                pend_blk_next   = (code == ate_pkg::CODE_BLOCK_MATCH)
                               || (code == ate_pkg::CODE_BLOCK_DELETE);
                prev_code_next  = code;
            end
        endcase
    end

    // Trace state registers, updated on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_del_reg   <= 1'b0;
            pend_blk_reg   <= 1'b0;
            pend_pos_reg   <= '0;
            pend_res_reg   <= '0;
            pend_real_reg  <= '0;
            pend_ins_reg   <= '0;
            entry_cnt_reg  <= '0;
            real_cnt_reg   <= '0;
            prev_code_reg  <= ate_pkg::CODE_END;
            open_cnt_reg   <= '0;
            del_cnt_reg    <= '0;
            ins_cnt_reg    <= '0;
            err_reg        <= ate_pkg::ERR_NONE;
        end
        else if (req_fire)
        begin
            pend_valid_reg <= pend_valid_next;
            pend_del_reg   <= pend_del_next;
            pend_blk_reg   <= pend_blk_next;
            pend_pos_reg   <= pend_pos_next;
            pend_res_reg   <= pend_res_next;
            pend_real_reg  <= pend_real_next;
            pend_ins_reg   <= pend_ins_next;
            entry_cnt_reg  <= entry_cnt_next;
            real_cnt_reg   <= real_cnt_next;
            prev_code_reg  <= prev_code_next;
            open_cnt_reg   <= open_cnt_next;
            del_cnt_reg    <= del_cnt_next;
            ins_cnt_reg    <= ins_cnt_next;
            err_reg        <= err_next;
        end
    end

    ate_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (req_fire && push),
        .push_item  (push_item),
        .push_ready (req_ready),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_item   (rsp_item)
    );

`ifndef SYNTHESIS
    // A stalled request side always means a result is on offer.
    assert property (@(posedge clk) disable iff (!rst_n) !req_ready |-> rsp_valid)
        else $error("request stalled with no result waiting");

    // The end code always yields a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req_item.req_type == ate_pkg::CODE_END) |=> rsp_valid)
        else $error("end code gave no result");

    // The end code leaves a cleared trace behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req_item.req_type == ate_pkg::CODE_END)
        |=> (!pend_valid_reg && err_reg == ate_pkg::ERR_NONE
             && prev_code_reg == ate_pkg::CODE_END && entry_cnt_reg == '0))
        else $error("trace state not cleared after end code");
`endif

endmodule

// ===== rtl/ate_cfg.sv =====
// Configuration register file of the alignment trace expander on an
// APB-style port. Depends on ate_pkg for the register type and addresses.
module ate_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output ate_pkg::cfg_regs_t  cfg
);

    ate_pkg::cfg_regs_t cfg_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register write in the access phase; the low address bits are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == ate_pkg::REG_SEQ_LENGTH)
            begin
                cfg_reg.seq_length <= pwdata[15:0];
            end
            else
            begin
                cfg_reg.start_index <= pwdata[15:0];
            end
        end
    end

    // Read-back of the addressed register.
    always_comb
    begin
        if (paddr[2] == ate_pkg::REG_SEQ_LENGTH)
        begin
            prdata = {16'd0, cfg_reg.seq_length};
        end
        else
        begin
            prdata = {16'd0, cfg_reg.start_index};
        end
    end

endmodule

// ===== rtl/ate_skid.sv =====
// Two-entry result queue (output register plus skid register) that lets the
// expander take a new request while a result waits. Depends on ate_pkg.
module ate_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ate_pkg::rsp_item_t  push_item,
    output logic                push_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ate_pkg::rsp_item_t  rsp_item
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    ate_pkg::rsp_item_t out_item_reg;
    ate_pkg::rsp_item_t skid_item_reg;
    logic               take;

    assign take       = out_valid_reg && rsp_ready;
    assign push_ready = !skid_valid_reg;
    assign rsp_valid  = out_valid_reg;
    assign rsp_item   = out_item_reg;

    // Valid flags of the two slots.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push && out_valid_reg && !take)
        begin
            skid_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload of the two slots.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_item_reg <= skid_item_reg;
            end
        end
        else if (push && out_valid_reg && !take)
        begin
            skid_item_reg <= push_item;
        end
        else if (push)
        begin
            out_item_reg <= push_item;
        end
    end

endmodule
